// ----- rtl/core/spmq_pkg.sv -----
// Shared types, constants and helpers for the strict-priority message queues.
// No dependencies; every other file in rtl/core imports this package.
package spmq_pkg;

  localparam int LEVELS    = 5;
  localparam int MAX_DEPTH = 16;
  localparam int ID_BITS   = 16;

  localparam int LVL_W     = 3;
  localparam int DEPTH_W   = $clog2(MAX_DEPTH);
  localparam int CNT_W     = DEPTH_W + 1;
  localparam int MEM_DEPTH = LEVELS * MAX_DEPTH;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int QIDX_W    = $clog2(LEVELS);
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 5;

  // Capacities after reset, one per level.
  localparam logic [CNT_W-1:0] CAP_RESET [LEVELS] = '{
    CNT_W'(4), CNT_W'(8), CNT_W'(8), CNT_W'(16), CNT_W'(16)
  };
  localparam logic [LVL_W-1:0] DROP_RESET = LVL_W'(4);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAP0 = 3'd0,
    REG_CAP1 = 3'd1,
    REG_CAP2 = 3'd2,
    REG_CAP3 = 3'd3,
    REG_CAP4 = 3'd4,
    REG_DROP = 3'd5
  } reg_idx_t;

  // Request commands.
  typedef enum logic {
    CMD_ENQ = 1'b0,
    CMD_DEQ = 1'b1
  } cmd_t;

  // Controller states.
  typedef enum logic {
    S_IDLE = 1'b0,
    S_RD   = 1'b1
  } state_t;

  // One access to the entry memory.
  typedef struct packed {
    logic               we;
    logic               re;
    logic [ADDR_W-1:0]  addr;
    logic [ID_BITS-1:0] wdata;
  } mem_req_t;

  // Result handed from the controller to the output register.
  typedef struct packed {
    logic             load;
    logic             ok;
    logic             dropped;
    logic [LVL_W-1:0] level;
    logic             use_mem;
  } res_t;

  // A written capacity of zero acts as one; above the depth it saturates.
  function automatic logic [CNT_W-1:0] clamp_cap(input logic [CFG_DAT_W-1:0] v);
    logic [CNT_W-1:0] r;
    begin
      if (v == '0) begin
        r = CNT_W'(1);
      end else if (CFG_DAT_W'(v) > CFG_DAT_W'(MAX_DEPTH)) begin
        r = CNT_W'(MAX_DEPTH);
      end else begin
        r = CNT_W'(v);
      end
      return r;
    end
  endfunction

endpackage

// ----- rtl/core/spmq_mem.sv -----
// Entry store of all queues: one synchronous RAM, one access per cycle.
// Depends on spmq_pkg for widths and the request struct.
module spmq_mem
  import spmq_pkg::*;
(
  input  logic               clk,
  input  mem_req_t           mem_req,
  output logic [ID_BITS-1:0] rd_data
);

  logic [ID_BITS-1:0] mem [MEM_DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (mem_req.we) begin
      mem[mem_req.addr] <= mem_req.wdata;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (mem_req.re) begin
      rd_data <= mem[mem_req.addr];
    end
  end

endmodule

// ----- rtl/core/spmq_ctrl.sv -----
// Queue controller: configuration, per-level head and fill pointers, and
// the request sequencer that drives the entry RAM. Depends on spmq_pkg.
module spmq_ctrl
  import spmq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata,
  input  logic                 in_valid,
  input  logic                 in_command,
  input  logic [LVL_W-1:0]     in_priority_req,
  input  logic [ID_BITS-1:0]   in_message_id,
  output logic                 in_stall,
  input  logic                 out_busy,
  output mem_req_t             mem_req,
  output res_t                 res
);

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cap_r  [LEVELS];
  logic [CNT_W-1:0]  cap_nxt[LEVELS];
  logic [DEPTH_W-1:0] head_r  [LEVELS];
  logic [DEPTH_W-1:0] head_nxt[LEVELS];
  logic [CNT_W-1:0]  fill_r  [LEVELS];
  logic [CNT_W-1:0]  fill_nxt[LEVELS];
  logic [LVL_W-1:0]  drop_r, drop_nxt;
  logic [LVL_W-1:0]  lvl_r, lvl_nxt;

  logic               accept;
  logic               all_empty;
  logic               lvl_ok;
  logic [QIDX_W-1:0]  eq;
  logic               full, drop, go;
  logic [CNT_W-1:0]   e_cap, e_fill, e_fill_new;
  logic [DEPTH_W-1:0] e_head, e_head_adv, e_head_new;
  logic [CNT_W-1:0]   tail_sum;
  logic [DEPTH_W-1:0] tail;
  logic               found;
  logic [QIDX_W-1:0]  dq;
  logic [DEPTH_W-1:0] d_head_adv;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE) || out_busy;

  // Configuration writes to capacities are taken only with every queue empty.
  always_comb begin
    all_empty = 1'b1;
    for (int i = 0; i < LEVELS; i++) begin
      if (fill_r[i] != '0) begin
        all_empty = 1'b0;
      end
    end
  end

  // Enqueue decision for the addressed level.
  always_comb begin
    lvl_ok     = in_priority_req < LVL_W'(LEVELS);
    eq         = lvl_ok ? QIDX_W'(in_priority_req) : '0;
    e_cap      = cap_r[eq];
    e_head     = head_r[eq];
    e_fill     = fill_r[eq];
    full       = e_fill >= e_cap;
    drop       = full && (in_priority_req == drop_r);
    go         = lvl_ok && (!full || drop);
    e_head_adv = ((CNT_W'(e_head) + CNT_W'(1)) >= e_cap) ? '0 : e_head + DEPTH_W'(1);
    e_head_new = drop ? e_head_adv : e_head;
    e_fill_new = drop ? e_fill - CNT_W'(1) : e_fill;
    tail_sum   = CNT_W'(e_head_new) + e_fill_new;
    if (tail_sum >= e_cap) begin
      tail_sum = tail_sum - e_cap;
    end
    tail       = tail_sum[DEPTH_W-1:0];
  end

  // Dequeue: the lowest-numbered level that holds an entry.
  always_comb begin
    found = 1'b0;
    dq    = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (fill_r[i] != '0) begin
        found = 1'b1;
        dq    = QIDX_W'(i);
      end
    end
    d_head_adv = ((CNT_W'(head_r[dq]) + CNT_W'(1)) >= cap_r[dq]) ? '0
               : head_r[dq] + DEPTH_W'(1);
  end

  // Sequencer, pointer updates, RAM requests and results.
  always_comb begin
    state_nxt = state_r;
    lvl_nxt   = lvl_r;
    drop_nxt  = drop_r;
    for (int i = 0; i < LEVELS; i++) begin
      cap_nxt[i]  = cap_r[i];
      head_nxt[i] = head_r[i];
      fill_nxt[i] = fill_r[i];
    end
    mem_req     = '0;
    mem_req.wdata = in_message_id;
    res         = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (cmd_t'(in_command) == CMD_ENQ) begin
            res.load    = 1'b1;
            res.ok      = go;
            res.dropped = go && drop;
            if (go) begin
              mem_req.we   = 1'b1;
              mem_req.addr = ADDR_W'(eq) * ADDR_W'(MAX_DEPTH) + ADDR_W'(tail);
              head_nxt[eq] = e_head_new;
              fill_nxt[eq] = e_fill_new + CNT_W'(1);
            end
          end else if (found) begin
            mem_req.re   = 1'b1;
            mem_req.addr = ADDR_W'(dq) * ADDR_W'(MAX_DEPTH) + ADDR_W'(head_r[dq]);
            head_nxt[dq] = d_head_adv;
            fill_nxt[dq] = fill_r[dq] - CNT_W'(1);
            lvl_nxt      = LVL_W'(dq);
            state_nxt    = S_RD;
          end else begin
            res.load = 1'b1;
          end
        end
      end
      S_RD: begin
        if (!out_busy) begin
          res.load    = 1'b1;
          res.ok      = 1'b1;
          res.level   = lvl_r;
          res.use_mem = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Configuration port; the user must write only while the block is idle, which the block does not enforce.
    if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_CAP0, REG_CAP1, REG_CAP2, REG_CAP3, REG_CAP4: begin
          if (all_empty) begin
            cap_nxt[QIDX_W'(cfg_index)]  = clamp_cap(cfg_wdata);
            head_nxt[QIDX_W'(cfg_index)] = '0;
          end
        end
        REG_DROP: begin
          drop_nxt = cfg_wdata[LVL_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      drop_r  <= DROP_RESET;
      lvl_r   <= '0;
      for (int i = 0; i < LEVELS; i++) begin
        cap_r[i]  <= CAP_RESET[i];
        head_r[i] <= '0;
        fill_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      drop_r  <= drop_nxt;
      lvl_r   <= lvl_nxt;
      for (int i = 0; i < LEVELS; i++) begin
        cap_r[i]  <= cap_nxt[i];
        head_r[i] <= head_nxt[i];
        fill_r[i] <= fill_nxt[i];
      end
    end
  end

`ifndef SYNTHESIS
  logic fill_in_range;

  always_comb begin
    fill_in_range = 1'b1;
    for (int i = 0; i < LEVELS; i++) begin
      if (fill_r[i] > cap_r[i]) begin
        fill_in_range = 1'b0;
      end
    end
  end

  // No queue ever holds more entries than its capacity.
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n) fill_in_range)
    else $error("queue fill exceeds capacity");

  // A RAM read is only issued for a level that holds an entry.
  a_read_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.re |-> (found && fill_r[dq] != '0))
    else $error("read issued on empty queue");

  // A read is always followed by the data-return state.
  a_read_then_rd: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.re |=> state_r == S_RD)
    else $error("read data not collected");

  // The RAM never reads and writes in the same cycle.
  a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_req.re && mem_req.we))
    else $error("read and write collide");
`endif

endmodule

// ----- rtl/core/strict_priority_message_queues.sv -----
// Top level of the strict-priority message queues: controller, entry RAM
// and the result register. Depends on spmq_pkg, spmq_ctrl and spmq_mem.
//
//  Channel  Ports                                        Direction
//  in       in_valid/in_stall, command, priority, id     request in
//  out      out_valid/out_stall, ok, dropped, level, id  result out
//  cfg      cfg_we, cfg_index, cfg_wdata                 register write
//
// An enqueue or a failed dequeue loads the result register when accepted; a successful
// dequeue first reads the entry RAM and loads its result from the read data in S_RD.
// Each request gives one result, held in an output register until taken.
// A new request is stalled while a dequeue waits for its RAM data, and while
// a result is waiting and the output is stalled.
// Reset is synchronous; the entry RAM is not cleared and needs no sweep.
module strict_priority_message_queues
  import spmq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_command,
  input  logic [LVL_W-1:0]     in_priority_req,
  input  logic [ID_BITS-1:0]   in_message_id,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_ok,
  output logic                 out_dropped_oldest,
  output logic [LVL_W-1:0]     out_level,
  output logic [ID_BITS-1:0]   out_message_id
);

  mem_req_t           mem_req;
  res_t               res;
  logic [ID_BITS-1:0] rd_data;
  logic               out_valid_r;
  logic               out_ok_r;
  logic               out_dropped_r;
  logic [LVL_W-1:0]   out_level_r;
  logic [ID_BITS-1:0] out_id_r;
  logic               out_busy;

  assign out_busy = out_valid_r && out_stall;

  spmq_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_command      (in_command),
    .in_priority_req (in_priority_req),
    .in_message_id   (in_message_id),
    .in_stall        (in_stall),
    .out_busy        (out_busy),
    .mem_req         (mem_req),
    .res             (res)
  );

  spmq_mem u_mem (
    .clk     (clk),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload; the controller loads only when the register is free.
  always_ff @(posedge clk) begin
    if (res.load) begin
      out_ok_r      <= res.ok;
      out_dropped_r <= res.dropped;
      out_level_r   <= res.level;
      out_id_r      <= res.use_mem ? rd_data : '0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_ok             = out_ok_r;
  assign out_dropped_oldest = out_dropped_r;
  assign out_level          = out_level_r;
  assign out_message_id     = out_id_r;

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for strict_priority_message_queues: a scoreboard class
// predicts every result from its own copy of the five priority queues.
// Depends on spmq_pkg and the RTL of the block; nothing else.
`timescale 1ns / 100ps

module tb_top;
  import spmq_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int RANDOM_PHASES  = 10;
  localparam int PHASE_REQUESTS = 120;

  // Register indexes past the last register; writes to them must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE7 = 3'd7;

  typedef struct packed {
    logic               ok;
    logic               dropped;
    logic [LVL_W-1:0]   level;
    logic [ID_BITS-1:0] id;
  } sched_result_t;

  // Scoreboard: keeps its own queues and settings and the results still owed.
  class sched_scoreboard;
    logic [CNT_W-1:0]   capacity [LEVELS];
    logic [LVL_W-1:0]   drop_level;
    logic [ID_BITS-1:0] entries [LEVELS][MAX_DEPTH];
    logic [DEPTH_W-1:0] head [LEVELS];
    logic [CNT_W-1:0]   fill [LEVELS];
    sched_result_t      expected_results [$];
    int                 mismatches;

    function new();
      int q;
      for (q = 0; q < LEVELS; q++) begin
        capacity[q] = CAP_RESET[q];
        head[q]     = '0;
        fill[q]     = '0;
      end
      drop_level = DROP_RESET;
      mismatches = 0;
    endfunction

    function int total_fill();
      int q;
      int n;
      n = 0;
      for (q = 0; q < LEVELS; q++) n += int'(fill[q]);
      return n;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // Head pointer of a queue after its oldest entry leaves; wraps at capacity.
    function logic [DEPTH_W-1:0] next_head(int q);
      if (int'(head[q]) + 1 >= int'(capacity[q])) return '0;
      return head[q] + 1'b1;
    endfunction

    // A capacity only changes while every queue is empty, and restarts its head.
    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] value);
      if (int'(idx) < LEVELS) begin
        if (total_fill() == 0) begin
          if (value == '0) capacity[idx] = CNT_W'(1);
          else if (int'(value) > MAX_DEPTH) capacity[idx] = CNT_W'(MAX_DEPTH);
          else capacity[idx] = CNT_W'(value);
          head[idx] = '0;
        end
      end else if (idx == REG_DROP) begin
        drop_level = value[LVL_W-1:0];
      end
    endfunction

    // Works out the result of an accepted request and queues it.
    function void note_request(cmd_t cmd, logic [LVL_W-1:0] prio, logic [ID_BITS-1:0] id);
      sched_result_t r;
      int q;
      int tail;
      bit go;
      bit found;
      r = '0;
      if (cmd == CMD_ENQ) begin
        if (int'(prio) < LEVELS) begin
          q  = int'(prio);
          go = 1'b1;
          if (fill[q] >= capacity[q]) begin
            if (prio == drop_level) begin
              // The full drop-oldest queue sheds its head to make room.
              head[q]   = next_head(q);
              fill[q]   = fill[q] - 1'b1;
              r.dropped = 1'b1;
            end else begin
              go = 1'b0;
            end
          end
          if (go) begin
            tail = int'(head[q]) + int'(fill[q]);
            if (tail >= int'(capacity[q])) tail -= int'(capacity[q]);
            entries[q][tail] = id;
            fill[q] = fill[q] + 1'b1;
            r.ok = 1'b1;
          end
        end
      end else begin
        // Dequeue from the lowest-numbered queue that holds anything.
        found = 1'b0;
        for (q = 0; q < LEVELS; q++) begin
          if (!found && fill[q] != '0) begin
            found   = 1'b1;
            r.ok    = 1'b1;
            r.level = LVL_W'(q);
            r.id    = entries[q][head[q]];
            head[q] = next_head(q);
            fill[q] = fill[q] - 1'b1;
          end
        end
      end
      expected_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [ID_BITS-1:0] want, logic [ID_BITS-1:0] got);
      if (want !== got) begin
        $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    // Compares a result taken from the block with the oldest one owed.
    function void check_result(logic ok, logic dropped, logic [LVL_W-1:0] level,
                               logic [ID_BITS-1:0] id);
      sched_result_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: result with no request waiting, expected none, actual ok %0b id %0h",
                 $time, ok, id);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        compare_field("ok", ID_BITS'(want.ok), ID_BITS'(ok));
        compare_field("dropped_oldest", ID_BITS'(want.dropped), ID_BITS'(dropped));
        compare_field("out_level", ID_BITS'(want.level), ID_BITS'(level));
        compare_field("out_message_id", want.id, id);
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_wdata;
  logic                 in_valid;
  logic                 in_stall;
  logic                 in_command;
  logic [LVL_W-1:0]     in_priority_req;
  logic [ID_BITS-1:0]   in_message_id;
  logic                 out_valid;
  logic                 out_stall;
  logic                 out_ok;
  logic                 out_dropped_oldest;
  logic [LVL_W-1:0]     out_level;
  logic [ID_BITS-1:0]   out_message_id;

  sched_scoreboard sb;
  bit              gaps_enabled = 1'b1;
  int              idle_cycles  = 0;

  strict_priority_message_queues dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_command         (in_command),
    .in_priority_req    (in_priority_req),
    .in_message_id      (in_message_id),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_ok             (out_ok),
    .out_dropped_oldest (out_dropped_oldest),
    .out_level          (out_level),
    .out_message_id     (out_message_id)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Monitor: every accepted request is predicted, every accepted result checked.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        sb.note_request(cmd_t'(in_command), in_priority_req, in_message_id);
      end
      if (out_valid && !out_stall) begin
        sb.check_result(out_ok, out_dropped_oldest, out_level, out_message_id);
      end
    end
  end

  // Watchdog: ends the run when nothing has moved for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver stalls in random bursts while gaps are enabled.
  initial begin
    out_stall <= 1'b0;
    forever begin
      repeat ($urandom_range(1, 8)) @(posedge clk);
      if (gaps_enabled && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Presents one request and holds it until it is accepted, then maybe pauses.
  task automatic send_request(input cmd_t cmd, input logic [LVL_W-1:0] prio,
                              input logic [ID_BITS-1:0] id);
    in_valid        <= 1'b1;
    in_command      <= cmd;
    in_priority_req <= prio;
    in_message_id   <= id;
    do @(posedge clk); while (in_stall);
    if (gaps_enabled && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Stops sending and waits until every owed result has been taken.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    sb.set_register(idx, value);
  endtask

  // Empties every queue so that new capacities take effect.
  task automatic drain_queues();
    settle();
    repeat (sb.total_fill()) begin
      send_request(CMD_DEQ, LVL_W'($urandom_range(0, 7)), ID_BITS'($urandom_range(0, 65535)));
    end
    settle();
  endtask

  // New random settings; small capacities dominate so that queues fill often.
  task automatic randomise_settings();
    int i;
    logic [CFG_DAT_W-1:0] value;
    for (i = 0; i < LEVELS; i++) begin
      case ($urandom_range(0, 7))
        0:       value = '0;
        1:       value = CFG_DAT_W'(1);
        2:       value = CFG_DAT_W'($urandom_range(1, 3));
        3:       value = CFG_DAT_W'(MAX_DEPTH);
        4:       value = CFG_DAT_W'($urandom_range(17, 31));
        default: value = CFG_DAT_W'($urandom_range(1, 16));
      endcase
      write_reg(reg_idx_t'(i), value);
    end
    if ($urandom_range(0, 4) == 0) value = CFG_DAT_W'($urandom_range(5, 31));
    else value = CFG_DAT_W'($urandom_range(0, 4));
    write_reg(REG_DROP, value);
    if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE6, CFG_DAT_W'($urandom_range(0, 31)));
    cfg_we <= 1'b0;
  endtask

  initial begin
    int phase;
    int k;
    int enq_pct;
    sb = new();
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= '0;
    cfg_wdata       <= '0;
    in_valid        <= 1'b0;
    in_command      <= CMD_ENQ;
    in_priority_req <= '0;
    in_message_id   <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: empty dequeue, levels out of range, a full queue that rejects.
    send_request(CMD_DEQ, LVL_W'(0), ID_BITS'(16'h5a5a));
    send_request(CMD_ENQ, LVL_W'(7), ID_BITS'(16'hffff));
    send_request(CMD_ENQ, LVL_W'(5), ID_BITS'(16'h0001));
    send_request(CMD_ENQ, LVL_W'(0), ID_BITS'(16'h0000));
    send_request(CMD_ENQ, LVL_W'(0), ID_BITS'(16'hffff));
    send_request(CMD_ENQ, LVL_W'(0), ID_BITS'(16'h1234));
    send_request(CMD_ENQ, LVL_W'(0), ID_BITS'(16'h8000));
    send_request(CMD_ENQ, LVL_W'(0), ID_BITS'(16'h7fff));
    send_request(CMD_ENQ, LVL_W'(2), ID_BITS'(16'haaaa));
    // A capacity write while queues hold entries must be ignored.
    settle();
    write_reg(REG_CAP0, CFG_DAT_W'(2));
    cfg_we <= 1'b0;
    send_request(CMD_ENQ, LVL_W'(0), ID_BITS'(16'h5555));
    repeat (6) send_request(CMD_DEQ, LVL_W'(4), ID_BITS'(16'hffff));

    // Capacity clamping, spare indexes and the drop-oldest path at level zero.
    settle();
    write_reg(REG_CAP0, CFG_DAT_W'(0));
    write_reg(REG_CAP1, CFG_DAT_W'(17));
    write_reg(REG_CAP4, CFG_DAT_W'(31));
    write_reg(REG_DROP, CFG_DAT_W'(0));
    write_reg(REG_SPARE6, CFG_DAT_W'(31));
    write_reg(REG_SPARE7, CFG_DAT_W'(0));
    cfg_we <= 1'b0;
    send_request(CMD_ENQ, LVL_W'(0), ID_BITS'(16'h0001));
    send_request(CMD_ENQ, LVL_W'(0), ID_BITS'(16'hfffe));
    send_request(CMD_DEQ, LVL_W'(0), ID_BITS'(16'h0000));
    send_request(CMD_DEQ, LVL_W'(0), ID_BITS'(16'h0000));
    // A drop-oldest level past the last level: every full queue rejects.
    settle();
    write_reg(REG_DROP, CFG_DAT_W'(13));
    cfg_we <= 1'b0;
    send_request(CMD_ENQ, LVL_W'(0), ID_BITS'(16'hc3c3));
    send_request(CMD_ENQ, LVL_W'(0), ID_BITS'(16'h3c3c));
    send_request(CMD_DEQ, LVL_W'(0), ID_BITS'(16'h0000));

    // Random phases, each under its own settings; the last ones run without gaps.
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      if ($urandom_range(0, 3) != 0) drain_queues();
      else settle();
      randomise_settings();
      gaps_enabled = (phase < RANDOM_PHASES - 2) && ($urandom_range(0, 3) != 0);
      enq_pct = $urandom_range(35, 85);
      for (k = 0; k < PHASE_REQUESTS; k++) begin
        if (k == PHASE_REQUESTS / 2 && phase % 3 == 0) settle();
        send_request(($urandom_range(0, 99) < enq_pct) ? CMD_ENQ : CMD_DEQ,
                     ($urandom_range(0, 9) == 0) ? LVL_W'($urandom_range(5, 7))
                                                 : LVL_W'($urandom_range(0, 4)),
                     ID_BITS'($urandom_range(0, 65535)));
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      if (sb.pending() != 0) $display("%0d expected results never arrived", sb.pending());
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
